>>> hdl/gclp_pkg.sv
package gclp_pkg;

    // sizes
    localparam int TEXT_DEPTH    = 128;
    localparam int NUMBER_CHARS  = 24;
    localparam int FRACTION_BITS = 16;
    localparam int VAL_W         = 40;
    localparam int TA_W          = $clog2(TEXT_DEPTH);
    localparam int TL_W          = $clog2(TEXT_DEPTH + 1);
    localparam int NI_W          = $clog2(NUMBER_CHARS);
    localparam int NC_W          = $clog2(NUMBER_CHARS + 1);
    localparam int BC_W          = $clog2(FRACTION_BITS + 1);
    localparam int MAG_W         = VAL_W + FRACTION_BITS + 1;
    localparam int CB_W          = 45;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [19:0] CODE_MAX = 20'd999999;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [7:0]              ch;
        logic signed [VAL_W-1:0] default_value;
    } gclp_in_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] value;
        logic                    truth;
        logic signed [31:0]      line_number;
        logic [7:0]              group_letter;
        logic [19:0]             command_code;
        logic [15:0]             check_value;
    } gclp_out_t;

    // saturating decimal accumulate
    function automatic logic [31:0] acc_digit(logic [31:0] a, logic [3:0] d);
        logic [31:0] r;
        if (a > 32'd429496728)
            r = '1;
        else
            r = a * 32'd10 + {28'd0, d};
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

>>> hdl/gclp_ram.sv
module gclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

>>> hdl/gcode_line_parser_top.sv
// G-code line parser. Raise start with cmd 0 to clear for a new line (busy
// stays low), cmd 1 to feed one line character, cmd 2 to query a parameter
// letter. A character keeps busy high while the parse step runs; the step is
// repeated when a byte closes a number and is then handled again. A query
// answers with a one-cycle done pulse; the receiver cannot stall, so result must
// be captured on that cycle. Query time is set by the single-port text memory
// and the decimal doubler: each stored byte up to the letter is read and then
// checked, each number character likewise, then the fraction digits are doubled
// once per binary fraction bit, and the result is built; an absent letter
// costs a read and a check of every stored byte.
module gcode_line_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gclp_pkg::gclp_in_t  item,
    output logic                busy,
    output logic                done,
    output gclp_pkg::gclp_out_t result
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_FEED    = 9'b000000010,
        ST_FIND_RD = 9'b000000100,
        ST_FIND_EV = 9'b000001000,
        ST_NUM_RD  = 9'b000010000,
        ST_NUM_EV  = 9'b000100000,
        ST_DBL     = 9'b001000000,
        ST_FIN     = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    typedef enum logic [9:0] {
        MD_LOOK        = 10'b0000000001,
        MD_NUM         = 10'b0000000010,
        MD_CODE_INT    = 10'b0000000100,
        MD_CODE_FRAC   = 10'b0000001000,
        MD_PARAM_START = 10'b0000010000,
        MD_PARAM       = 10'b0000100000,
        MD_CHECK       = 10'b0001000000,
        MD_CHECK_DONE  = 10'b0010000000,
        MD_COMMENT     = 10'b0100000000,
        MD_DONE        = 10'b1000000000
    } mode_t;

    localparam logic [gclp_pkg::TL_W-1:0] LEN_MAX = gclp_pkg::TL_W'(gclp_pkg::TEXT_DEPTH);
    localparam logic [gclp_pkg::NC_W-1:0] CNT_MAX =
        gclp_pkg::NC_W'(gclp_pkg::NUMBER_CHARS);
    localparam logic [gclp_pkg::BC_W-1:0] BIT_LAST =
        gclp_pkg::BC_W'(gclp_pkg::FRACTION_BITS);
    localparam logic [gclp_pkg::MAG_W-1:0] LIM = gclp_pkg::MAG_W'(1) << (gclp_pkg::VAL_W - 1);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next, resume_reg, resume_next;

    logic [7:0]  ch_reg, ch_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next, sign_reg, sign_next, dig_reg, dig_next;
    logic signed [gclp_pkg::CB_W-1:0] cb_reg, cb_next;
    logic signed [31:0] line_reg, line_next;
    logic [7:0]  group_reg, group_next;
    logic [19:0] code_reg, code_next;
    logic [15:0] check_reg, check_next;
    logic [gclp_pkg::TL_W-1:0] len_reg, len_next;

    // query registers
    logic [7:0] letter_reg, letter_next;
    logic signed [gclp_pkg::VAL_W-1:0] dflt_reg, dflt_next;
    logic [gclp_pkg::TL_W-1:0] ptr_reg, ptr_next;
    logic [gclp_pkg::NC_W-1:0] cnt_reg, cnt_next, nf_reg, nf_next, jd_reg, jd_next;
    logic [gclp_pkg::BC_W-1:0] bcnt_reg, bcnt_next;
    logic [gclp_pkg::FRACTION_BITS:0] bits_reg, bits_next;
    logic carry_reg, carry_next;
    logic [gclp_pkg::VAL_W-1:0] ip_reg, ip_next;
    logic hit_reg, hit_next, qneg_reg, qneg_next, frac_reg, frac_next;
    logic ended_reg, ended_next, nz_reg, nz_next, first_reg, first_next;
    gclp_pkg::gclp_out_t result_reg, result_next;

    // fraction digits
    logic [3:0] fd_reg [gclp_pkg::NUMBER_CHARS];
    logic       fd_we;
    logic [gclp_pkg::NI_W-1:0] fd_idx;
    logic [3:0] fd_wd;

    // text memory port
    logic       put_en;
    logic [7:0] put_ch;
    logic       ram_we;
    logic [gclp_pkg::TA_W-1:0] ram_addr;
    logic [7:0] rd_data;

    // finish of the pending number
    logic signed [32:0] sacc;
    logic signed [gclp_pkg::CB_W-1:0] frac_sum;
    mode_t       fin_mode;
    logic signed [31:0] fin_line;
    logic [19:0] fin_code;
    logic [15:0] fin_check;
    logic        fin_put;
    logic [7:0]  fin_ch;

    // query helpers
    logic [gclp_pkg::VAL_W+3:0] ip10;
    logic [4:0] dbl_t;
    logic [gclp_pkg::FRACTION_BITS+1:0] rnd;
    logic [gclp_pkg::MAG_W-1:0] mag, mag_sat;
    logic blank, again;

    gclp_ram #(
        .WIDTH(8),
        .DEPTH(gclp_pkg::TEXT_DEPTH)
    ) u_text (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(put_ch),
        .rdata(rd_data)
    );

    assign ram_we   = put_en && (len_reg < LEN_MAX);
    assign ram_addr = put_en ? len_reg[gclp_pkg::TA_W-1:0] : ptr_reg[gclp_pkg::TA_W-1:0];

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_OUT);
    assign result = result_reg;

    // signed view of the accumulator
    assign sacc = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign frac_sum = cb_reg + $signed({{(gclp_pkg::CB_W-32){1'b0}}, acc_reg});

    // close the number being read
    always_comb
    begin
        fin_mode  = mode_reg;
        fin_line  = line_reg;
        fin_code  = code_reg;
        fin_check = check_reg;
        fin_put   = 1'b0;
        fin_ch    = neg_reg ? gclp_pkg::CH_MINUS : gclp_pkg::CH_PLUS;
        unique case (mode_reg)
            MD_NUM:
            begin
                if (sacc[32] != sacc[31])
                    fin_line = sacc[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    fin_line = sacc[31:0];
                fin_mode = MD_LOOK;
            end
            MD_CODE_INT:
            begin
                if (sacc[32])
                    fin_code = '0;
                else if (sacc[31:0] > {12'd0, gclp_pkg::CODE_MAX})
                    fin_code = gclp_pkg::CODE_MAX;
                else
                    fin_code = sacc[19:0];
                if (sign_reg && !dig_reg)
                begin
                    fin_code = '0;
                    fin_put  = 1'b1;
                    fin_mode = MD_PARAM;
                end
                else
                    fin_mode = MD_PARAM_START;
            end
            MD_CODE_FRAC:
            begin
                if (frac_sum[gclp_pkg::CB_W-1])
                    fin_code = '0;
                else if (frac_sum > $signed({{(gclp_pkg::CB_W-20){1'b0}}, gclp_pkg::CODE_MAX}))
                    fin_code = gclp_pkg::CODE_MAX;
                else
                    fin_code = frac_sum[19:0];
                fin_mode = MD_PARAM_START;
            end
            MD_CHECK:
            begin
                if (sacc[32])
                    fin_check = '0;
                else if (sacc[31:16] != 16'd0)
                    fin_check = '1;
                else
                    fin_check = sacc[15:0];
                fin_mode = MD_CHECK_DONE;
            end
            default:
            begin
                fin_mode = mode_reg;
            end
        endcase
    end

    assign blank = (ch_reg == gclp_pkg::CH_SP) || (ch_reg == gclp_pkg::CH_TAB)
                || (ch_reg == gclp_pkg::CH_CR) || (ch_reg == gclp_pkg::CH_VT)
                || (ch_reg == gclp_pkg::CH_FF);

    assign ip10  = {4'd0, ip_reg} * 44'd10 + {40'd0, rd_data[3:0]};
    assign dbl_t = {fd_reg[fd_idx], 1'b0} + {4'd0, carry_reg};
    assign rnd   = ({1'b0, bits_reg} + 1'b1) >> 1;
    assign mag   = {1'b0, ip_reg, {gclp_pkg::FRACTION_BITS{1'b0}}}
                 + {{(gclp_pkg::MAG_W-gclp_pkg::FRACTION_BITS-2){1'b0}}, rnd};

    always_comb
    begin
        if (qneg_reg)
            mag_sat = (mag > LIM) ? LIM : mag;
        else
            mag_sat = (mag > LIM - 1'b1) ? LIM - 1'b1 : mag;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        resume_next = resume_reg;
        ch_next     = ch_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        sign_next   = sign_reg;
        dig_next    = dig_reg;
        cb_next     = cb_reg;
        line_next   = line_reg;
        group_next  = group_reg;
        code_next   = code_reg;
        check_next  = check_reg;
        len_next    = len_reg;
        letter_next = letter_reg;
        dflt_next   = dflt_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        nf_next     = nf_reg;
        jd_next     = jd_reg;
        bcnt_next   = bcnt_reg;
        bits_next   = bits_reg;
        carry_next  = carry_reg;
        ip_next     = ip_reg;
        hit_next    = hit_reg;
        qneg_next   = qneg_reg;
        frac_next   = frac_reg;
        ended_next  = ended_reg;
        nz_next     = nz_reg;
        first_next  = first_reg;
        result_next = result_reg;
        put_en      = 1'b0;
        put_ch      = ch_reg;
        fd_we       = 1'b0;
        fd_idx      = gclp_pkg::NI_W'(jd_reg - 1'b1);
        fd_wd       = dbl_t[3:0];
        again       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (item.cmd)
                        gclp_pkg::CMD_CLEAR:
                        begin
                            mode_next   = MD_LOOK;
                            resume_next = MD_LOOK;
                            acc_next    = '0;
                            neg_next    = 1'b0;
                            sign_next   = 1'b0;
                            dig_next    = 1'b0;
                            cb_next     = '0;
                            line_next   = '0;
                            group_next  = '0;
                            code_next   = '0;
                            check_next  = '0;
                            len_next    = '0;
                        end
                        gclp_pkg::CMD_CHAR:
                        begin
                            ch_next    = item.ch;
                            state_next = ST_FEED;
                        end
                        gclp_pkg::CMD_QUERY:
                        begin
                            letter_next = item.ch;
                            dflt_next   = item.default_value;
                            ptr_next    = '0;
                            cnt_next    = '0;
                            nf_next     = '0;
                            bcnt_next   = '0;
                            bits_next   = '0;
                            carry_next  = 1'b0;
                            ip_next     = '0;
                            hit_next    = 1'b0;
                            qneg_next   = 1'b0;
                            frac_next   = 1'b0;
                            ended_next  = 1'b0;
                            nz_next     = 1'b0;
                            first_next  = 1'b0;
                            state_next  = (item.ch == gclp_pkg::CH_NUL) ? ST_FIN : ST_FIND_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // one parse step per cycle, repeated when the byte is handled again
            ST_FEED:
            begin
                if (mode_reg == MD_DONE)
                    again = 1'b0;
                else if (mode_reg == MD_COMMENT)
                begin
                    if (ch_reg == gclp_pkg::CH_NUL)
                        mode_next = MD_DONE;
                    else if (ch_reg == gclp_pkg::CH_RPAR)
                        mode_next = resume_reg;
                end
                else if ((ch_reg == gclp_pkg::CH_SEMI) || (ch_reg == gclp_pkg::CH_NL)
                      || (ch_reg == gclp_pkg::CH_NUL))
                begin
                    line_next  = fin_line;
                    code_next  = fin_code;
                    check_next = fin_check;
                    put_en     = fin_put;
                    put_ch     = fin_ch;
                    mode_next  = MD_DONE;
                end
                else
                begin
                    unique case (mode_reg)
                        MD_LOOK:
                        begin
                            if (ch_reg == gclp_pkg::CH_N)
                            begin
                                acc_next  = '0;
                                neg_next  = 1'b0;
                                sign_next = 1'b0;
                                dig_next  = 1'b0;
                                mode_next = MD_NUM;
                            end
                            else if (ch_reg == gclp_pkg::CH_LPAR)
                            begin
                                resume_next = MD_LOOK;
                                mode_next   = MD_COMMENT;
                            end
                            else if ((ch_reg == gclp_pkg::CH_G) || (ch_reg == gclp_pkg::CH_M)
                                  || (ch_reg == gclp_pkg::CH_T) || (ch_reg == gclp_pkg::CH_F))
                            begin
                                group_next = ch_reg;
                                acc_next   = '0;
                                neg_next   = 1'b0;
                                sign_next  = 1'b0;
                                dig_next   = 1'b0;
                                mode_next  = MD_CODE_INT;
                            end
                        end
                        MD_NUM, MD_CODE_INT, MD_CHECK:
                        begin
                            if (!sign_reg && !dig_reg && blank)
                                again = 1'b0;
                            else if (!sign_reg && !dig_reg
                                  && ((ch_reg == gclp_pkg::CH_PLUS)
                                   || (ch_reg == gclp_pkg::CH_MINUS)))
                            begin
                                sign_next = 1'b1;
                                neg_next  = (ch_reg == gclp_pkg::CH_MINUS);
                            end
                            else if (gclp_pkg::is_digit(ch_reg))
                            begin
                                acc_next = gclp_pkg::acc_digit(acc_reg, ch_reg[3:0]);
                                dig_next = 1'b1;
                            end
                            else if ((mode_reg == MD_CODE_INT) && (ch_reg == gclp_pkg::CH_DOT)
                                  && !(sign_reg && !dig_reg))
                            begin
                                cb_next   = gclp_pkg::CB_W'(sacc) * gclp_pkg::CB_W'(1000);
                                acc_next  = '0;
                                neg_next  = 1'b0;
                                sign_next = 1'b0;
                                dig_next  = 1'b0;
                                mode_next = MD_CODE_FRAC;
                            end
                            else
                            begin
                                line_next  = fin_line;
                                code_next  = fin_code;
                                check_next = fin_check;
                                put_en     = fin_put;
                                put_ch     = fin_ch;
                                mode_next  = fin_mode;
                                again      = 1'b1;
                            end
                        end
                        MD_CODE_FRAC:
                        begin
                            if (gclp_pkg::is_digit(ch_reg))
                                acc_next = gclp_pkg::acc_digit(acc_reg, ch_reg[3:0]);
                            else
                            begin
                                code_next = fin_code;
                                mode_next = fin_mode;
                                again     = 1'b1;
                            end
                        end
                        MD_PARAM_START:
                        begin
                            if ((ch_reg != gclp_pkg::CH_SP) && (ch_reg != gclp_pkg::CH_TAB))
                            begin
                                mode_next = MD_PARAM;
                                again     = 1'b1;
                            end
                        end
                        MD_PARAM:
                        begin
                            if (ch_reg == gclp_pkg::CH_LPAR)
                            begin
                                resume_next = MD_PARAM_START;
                                mode_next   = MD_COMMENT;
                            end
                            else if (ch_reg == gclp_pkg::CH_STAR)
                            begin
                                acc_next  = '0;
                                neg_next  = 1'b0;
                                sign_next = 1'b0;
                                dig_next  = 1'b0;
                                mode_next = MD_CHECK;
                            end
                            else
                                put_en = 1'b1;
                        end
                        MD_CHECK_DONE:
                        begin
                            if (ch_reg == gclp_pkg::CH_LPAR)
                            begin
                                resume_next = MD_CHECK_DONE;
                                mode_next   = MD_COMMENT;
                            end
                        end
                        default:
                        begin
                            mode_next = MD_DONE;
                        end
                    endcase
                end
                if (put_en && (len_reg < LEN_MAX))
                    len_next = len_reg + 1'b1;
                state_next = again ? ST_FEED : ST_IDLE;
            end

            // search the text for the letter
            ST_FIND_RD:
            begin
                state_next = (ptr_reg < len_reg) ? ST_FIND_EV : ST_FIN;
            end
            ST_FIND_EV:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (rd_data == letter_reg)
                begin
                    hit_next   = 1'b1;
                    first_next = 1'b1;
                    state_next = ST_NUM_RD;
                end
                else
                    state_next = ST_FIND_RD;
            end

            // collect the number after the letter
            ST_NUM_RD:
            begin
                jd_next = nf_reg;
                if ((ptr_reg < len_reg) && (first_reg || (cnt_reg < CNT_MAX)))
                    state_next = ST_NUM_EV;
                else
                    state_next = (cnt_reg == '0) ? ST_FIN : ST_DBL;
            end
            ST_NUM_EV:
            begin
                first_next = 1'b0;
                jd_next    = nf_reg;
                state_next = ST_NUM_RD;
                if (first_reg && ((rd_data == gclp_pkg::CH_PLUS)
                               || (rd_data == gclp_pkg::CH_MINUS)))
                begin
                    qneg_next = (rd_data == gclp_pkg::CH_MINUS);
                    cnt_next  = cnt_reg + 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                else if (first_reg || (cnt_reg < CNT_MAX))
                begin
                    if (rd_data == gclp_pkg::CH_DOT)
                    begin
                        ended_next = ended_reg | frac_reg;
                        frac_next  = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                        ptr_next   = ptr_reg + 1'b1;
                    end
                    else if (gclp_pkg::is_digit(rd_data))
                    begin
                        if (!ended_reg)
                        begin
                            if (rd_data != gclp_pkg::CH_0)
                                nz_next = 1'b1;
                            if (frac_reg)
                            begin
                                fd_we   = 1'b1;
                                fd_idx  = gclp_pkg::NI_W'(nf_reg);
                                fd_wd   = rd_data[3:0];
                                nf_next = nf_reg + 1'b1;
                            end
                            else if (ip10 > {4'd0, LIM[gclp_pkg::VAL_W-1:0]})
                                ip_next = LIM[gclp_pkg::VAL_W-1:0];
                            else
                                ip_next = ip10[gclp_pkg::VAL_W-1:0];
                        end
                        cnt_next = cnt_reg + 1'b1;
                        ptr_next = ptr_reg + 1'b1;
                    end
                    else
                        state_next = (cnt_reg == '0) ? ST_FIN : ST_DBL;
                end
                else
                    state_next = (cnt_reg == '0) ? ST_FIN : ST_DBL;
            end

            // decimal fraction doubled one digit per cycle
            ST_DBL:
            begin
                if (jd_reg != '0)
                begin
                    fd_we      = 1'b1;
                    fd_wd      = (dbl_t >= 5'd10) ? 4'(dbl_t - 5'd10) : dbl_t[3:0];
                    carry_next = (dbl_t >= 5'd10);
                    jd_next    = jd_reg - 1'b1;
                end
                else
                begin
                    bits_next  = {bits_reg[gclp_pkg::FRACTION_BITS-1:0], carry_reg};
                    carry_next = 1'b0;
                    jd_next    = nf_reg;
                    if (bcnt_reg == BIT_LAST)
                        state_next = ST_FIN;
                    else
                        bcnt_next = bcnt_reg + 1'b1;
                end
            end

            // build the result beat
            ST_FIN:
            begin
                result_next.found        = hit_reg;
                result_next.line_number  = line_reg;
                result_next.group_letter = group_reg;
                result_next.command_code = code_reg;
                result_next.check_value  = check_reg;
                result_next.value        = dflt_reg;
                result_next.truth        = 1'b0;
                if (hit_reg)
                begin
                    if (cnt_reg == '0)
                        result_next.truth = 1'b1;
                    else
                    begin
                        result_next.truth = nz_reg;
                        if (qneg_reg)
                            result_next.value = -$signed(mag_sat[gclp_pkg::VAL_W-1:0]);
                        else
                            result_next.value = $signed(mag_sat[gclp_pkg::VAL_W-1:0]);
                    end
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fd_we)
            fd_reg[fd_idx] <= fd_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MD_LOOK;
            resume_reg <= MD_LOOK;
            ch_reg     <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            sign_reg   <= 1'b0;
            dig_reg    <= 1'b0;
            cb_reg     <= '0;
            line_reg   <= '0;
            group_reg  <= '0;
            code_reg   <= '0;
            check_reg  <= '0;
            len_reg    <= '0;
            letter_reg <= '0;
            dflt_reg   <= '0;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            nf_reg     <= '0;
            jd_reg     <= '0;
            bcnt_reg   <= '0;
            bits_reg   <= '0;
            carry_reg  <= 1'b0;
            ip_reg     <= '0;
            hit_reg    <= 1'b0;
            qneg_reg   <= 1'b0;
            frac_reg   <= 1'b0;
            ended_reg  <= 1'b0;
            nz_reg     <= 1'b0;
            first_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            resume_reg <= resume_next;
            ch_reg     <= ch_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            sign_reg   <= sign_next;
            dig_reg    <= dig_next;
            cb_reg     <= cb_next;
            line_reg   <= line_next;
            group_reg  <= group_next;
            code_reg   <= code_next;
            check_reg  <= check_next;
            len_reg    <= len_next;
            letter_reg <= letter_next;
            dflt_reg   <= dflt_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            nf_reg     <= nf_next;
            jd_reg     <= jd_next;
            bcnt_reg   <= bcnt_next;
            bits_reg   <= bits_next;
            carry_reg  <= carry_next;
            ip_reg     <= ip_next;
            hit_reg    <= hit_next;
            qneg_reg   <= qneg_next;
            frac_reg   <= frac_next;
            ended_reg  <= ended_next;
            nz_reg     <= nz_next;
            first_reg  <= first_next;
            result_reg <= result_next;
        end
    end

endmodule

>>> hdl/gclp_checker.sv
module gclp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input gclp_pkg::gclp_in_t item
);

    // a result beat only comes while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    // a query beat always makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd == gclp_pkg::CMD_QUERY)) |=> busy)
        else $error("query not taken up");

    // clear and character beats give no result next cycle
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd != gclp_pkg::CMD_QUERY)) |=> !done)
        else $error("result without a query");

    // one result beat per query
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result beat repeated");

endmodule

bind gcode_line_parser_top gclp_checker u_gclp_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (done),
    .item (item)
);
